### rtl/msd_pkg.sv
// ============================================================================
// msd_pkg : shared types and constants of the multi-switch debouncer
// Function codes, debounce and press-once state encodings, lane control
// and result records.
// ============================================================================
package msd_pkg;

    localparam int FUNC_W = 2;
    localparam int PIN_W  = 8;
    localparam int IDX_W  = 8;
    localparam int MASK_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_GET      = 2'd1,
        FUNC_GET_ONCE = 2'd2,
        FUNC_INIT     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        DEB_RELEASED     = 2'd0,
        DEB_PRE_PRESSED  = 2'd1,
        DEB_PRESSED      = 2'd2,
        DEB_PRE_RELEASED = 2'd3
    } t_deb_state;

    typedef enum logic [1:0] {
        ONCE_RELEASED     = 2'd0,
        ONCE_PRESSED      = 2'd1,
        ONCE_POST_PRESSED = 2'd2
    } t_once_state;

    typedef struct packed {
        logic tick_en;
        logic init_en;
        logic once_en;
    } t_lane_ctrl;

    typedef struct packed {
        logic switch_level;
        logic status;
    } t_result;

endpackage

### rtl/msd_if.sv
// ============================================================================
// msd_if : handshake channels of the multi-switch debouncer
// Request, result and configuration channels, each with valid and ready.
// ============================================================================
interface msd_in_if;
    logic                       valid;
    logic                       ready;
    logic [msd_pkg::FUNC_W-1:0] func;
    logic [msd_pkg::PIN_W-1:0]  pin_levels;
    logic [msd_pkg::IDX_W-1:0]  switch_index;

    modport source (output valid, output func, output pin_levels,
                    output switch_index, input ready);
    modport sink   (input valid, input func, input pin_levels,
                    input switch_index, output ready);
endinterface

interface msd_out_if;
    logic valid;
    logic ready;
    logic switch_level;
    logic status;

    modport source (output valid, output switch_level, output status, input ready);
    modport sink   (input valid, input switch_level, input status, output ready);
endinterface

interface msd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [msd_pkg::MASK_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/msd_lane.sv
// ============================================================================
// msd_lane : one switch's debouncer and press-once tracker
// Four-state debounce machine, debounced level and press-once machine.
// ============================================================================
module msd_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msd_pkg::t_lane_ctrl i_ctrl,
    input  logic                i_pin,        // polarity corrected
    input  logic                i_init_level,
    output logic                o_level,
    output logic                o_once
);

    msd_pkg::t_deb_state  r_deb,  n_deb;
    msd_pkg::t_once_state r_once, n_once;
    logic                 r_level, n_level;
    logic                 deb_level;

    // debounce next state
    always_comb begin
        case (r_deb)
            msd_pkg::DEB_RELEASED: begin
                n_deb = i_pin ? msd_pkg::DEB_PRE_PRESSED : msd_pkg::DEB_RELEASED;
            end
            msd_pkg::DEB_PRE_PRESSED: begin
                n_deb = i_pin ? msd_pkg::DEB_PRESSED : msd_pkg::DEB_RELEASED;
            end
            msd_pkg::DEB_PRESSED: begin
                n_deb = i_pin ? msd_pkg::DEB_PRESSED : msd_pkg::DEB_PRE_RELEASED;
            end
            default: begin
                n_deb = i_pin ? msd_pkg::DEB_PRESSED : msd_pkg::DEB_RELEASED;
            end
        endcase
    end

    // debounce output: level seen in the current state
    always_comb begin
        case (r_deb)
            msd_pkg::DEB_PRESSED,
            msd_pkg::DEB_PRE_RELEASED: deb_level = 1'b1;
            default:                   deb_level = 1'b0;
        endcase
    end

    // press-once next state
    always_comb begin
        case (r_once)
            msd_pkg::ONCE_RELEASED: begin
                n_once = r_level ? msd_pkg::ONCE_PRESSED : msd_pkg::ONCE_RELEASED;
            end
            default: begin
                n_once = r_level ? msd_pkg::ONCE_POST_PRESSED : msd_pkg::ONCE_RELEASED;
            end
        endcase
    end

    // press-once output
    always_comb begin
        case (r_once)
            msd_pkg::ONCE_PRESSED: o_once = 1'b1;
            default:               o_once = 1'b0;
        endcase
    end

    always_comb begin
        n_level = r_level;
        if (i_ctrl.tick_en) begin
            n_level = deb_level;
        end else if (i_ctrl.init_en) begin
            n_level = i_init_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb   <= msd_pkg::DEB_RELEASED;
            r_once  <= msd_pkg::ONCE_RELEASED;
            r_level <= 1'b0;
        end else begin
            r_level <= n_level;
            if (i_ctrl.tick_en) begin
                r_deb <= n_deb;
            end
            if (i_ctrl.once_en) begin
                r_once <= n_once;
            end
        end
    end

    assign o_level = r_level;

endmodule

### rtl/msd_merge.sv
// ============================================================================
// msd_merge : result selection across the switch lanes
// Picks the asked switch's level or once pulse and forms the status.
// ============================================================================
module msd_merge #(
    parameter int SWITCH_COUNT = 8
) (
    input  msd_pkg::t_func             i_func,
    input  logic [msd_pkg::IDX_W-1:0]  i_switch_index,
    input  logic                       i_initialized,
    input  logic [SWITCH_COUNT-1:0]    i_levels,
    input  logic [SWITCH_COUNT-1:0]    i_onces,
    output msd_pkg::t_result           o_result,
    output logic [SWITCH_COUNT-1:0]    o_once_hit
);

    localparam int                       SelW  = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam logic [msd_pkg::IDX_W-1:0] Count = msd_pkg::IDX_W'(SWITCH_COUNT);

    logic            in_range;
    logic            query_ok;
    logic [SelW-1:0] sel;
    logic            sel_level;
    logic            sel_once;

    assign in_range  = (i_switch_index < Count);
    assign query_ok  = i_initialized && in_range;
    assign sel       = i_switch_index[SelW-1:0];
    assign sel_level = in_range ? i_levels[sel] : 1'b0;
    assign sel_once  = in_range ? i_onces[sel]  : 1'b0;

    always_comb begin
        o_result = '0;
        case (i_func)
            msd_pkg::FUNC_TICK: begin
                o_result.status = !i_initialized;
            end
            msd_pkg::FUNC_GET: begin
                o_result.status       = !query_ok;
                o_result.switch_level = query_ok && sel_level;
            end
            msd_pkg::FUNC_GET_ONCE: begin
                o_result.status       = !query_ok;
                o_result.switch_level = query_ok && sel_once;
            end
            default: begin
                o_result.status = 1'b0;
            end
        endcase
    end

    // one-hot lane pick for a get-once step
    always_comb begin
        o_once_hit = '0;
        if (i_func == msd_pkg::FUNC_GET_ONCE && query_ok) begin
            o_once_hit[sel] = 1'b1;
        end
    end

endmodule

### rtl/multi_switch_debouncer_top.sv
// ============================================================================
// multi_switch_debouncer_top : debouncer for a bank of switches
// One lane per switch steps in parallel on a tick; a merge stage answers
// get and get-once queries; a two-entry output buffer holds results.
// ============================================================================
//
//  channel    dir  payload                               transaction
//  ---------  ---  ------------------------------------  ---------------------
//  i_in_ch    in   func, pin_levels, switch_index        one request
//  o_out_ch   out  switch_level, status                  one result / request
//  i_cfg_ch   in   data (active_low_mask)                one mask write
//
//  The lanes a request steps update at the accepting edge and its result
//  is registered at that edge, in the output register or the skid entry.
//  The output buffer sustains one transaction per cycle while sink is ready.
//  Reset is synchronous, active low; it clears all lane states, levels,
//  the mask and the initialized flag. No clearing pass is needed.
//  When the sink stalls, the output register holds one result and a skid
//  entry takes one more; ready drops only while the skid entry is full.
//
module multi_switch_debouncer_top #(
    parameter int SWITCH_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msd_in_if.sink     i_in_ch,
    msd_out_if.source  o_out_ch,
    msd_cfg_if.sink    i_cfg_ch
);

    logic [msd_pkg::MASK_W-1:0] r_mask;
    logic                       r_initialized;

    msd_pkg::t_result r_out,       n_out;
    logic             r_out_valid, n_out_valid;
    msd_pkg::t_result r_skid,      n_skid;
    logic             r_skid_valid, n_skid_valid;

    msd_pkg::t_func            func;
    logic                      in_accept;
    logic                      out_fire;
    logic [SWITCH_COUNT-1:0]   levels;
    logic [SWITCH_COUNT-1:0]   onces;
    logic [SWITCH_COUNT-1:0]   once_hit;
    logic [SWITCH_COUNT-1:0]   once_en;
    msd_pkg::t_result          result;
    logic                      tick_go;
    logic                      init_go;

    assign func      = msd_pkg::t_func'(i_in_ch.func);
    assign in_accept = i_in_ch.valid && i_in_ch.ready;
    assign out_fire  = r_out_valid && o_out_ch.ready;

    // Tick steps only after init; init always goes through.
    assign tick_go = in_accept && (func == msd_pkg::FUNC_TICK) && r_initialized;
    assign init_go = in_accept && (func == msd_pkg::FUNC_INIT);
    assign once_en = in_accept ? once_hit : '0;

    // Mask register, written any time the port offers data.
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask        <= '0;
            r_initialized <= 1'b0;
        end else begin
            if (i_cfg_ch.valid) begin
                r_mask <= i_cfg_ch.data;
            end
            if (init_go) begin
                r_initialized <= 1'b1;
            end
        end
    end

    // Lanes: switches past the pin word see a low pin and are active high.
    for (genvar g = 0; g < SWITCH_COUNT; g++) begin : g_lane
        logic                lane_pin;
        logic                lane_init;
        msd_pkg::t_lane_ctrl lane_ctrl;

        if (g < msd_pkg::PIN_W) begin : g_pin
            assign lane_pin  = i_in_ch.pin_levels[g] ^ r_mask[g];
            assign lane_init = r_mask[g];
        end else begin : g_nopin
            assign lane_pin  = 1'b0;
            assign lane_init = 1'b0;
        end

        assign lane_ctrl.tick_en = tick_go;
        assign lane_ctrl.init_en = init_go;
        assign lane_ctrl.once_en = once_en[g];

        msd_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (lane_ctrl),
            .i_pin        (lane_pin),
            .i_init_level (lane_init),
            .o_level      (levels[g]),
            .o_once       (onces[g])
        );
    end

    msd_merge #(
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_merge (
        .i_func         (func),
        .i_switch_index (i_in_ch.switch_index),
        .i_initialized  (r_initialized),
        .i_levels       (levels),
        .i_onces        (onces),
        .o_result       (result),
        .o_once_hit     (once_hit)
    );

    // Output buffer: main register plus one skid entry.
    assign i_in_ch.ready = !r_skid_valid;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_fire) begin
            if (r_skid_valid) begin
                // advance the skid entry; no request is taken this cycle
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (in_accept) begin
                n_out = result;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                // hold the waiting result, park the new one
                n_skid       = result;
                n_skid_valid = 1'b1;
            end else begin
                n_out       = result;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.switch_level = r_out.switch_level;
    assign o_out_ch.status       = r_out.status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_no_skid_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_out_valid) |=> !r_skid_valid)
        else $error("request parked in skid though output register was free");

    a_once_single_lane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(once_en))
        else $error("get-once stepped more than one lane");

    a_init_sets_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_go |=> r_initialized)
        else $error("initialize did not set the initialized flag");

    a_tick_needs_init : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_go |-> r_initialized)
        else $error("lanes stepped before initialize");

endmodule
